### hdl/dgf_pkg.sv
// Shared types, constants and the dither threshold table for the dithered
// gradient fill core. Depends on nothing; used by dgf_divider and the top level.
package dgf_pkg;

  // Fixed field widths of the pixel transaction and the configuration port.
  localparam int unsigned ROW_W      = 11;
  localparam int unsigned COL_W      = 11;
  localparam int unsigned PIX_W      = 11;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned STEPS_W    = 5;
  localparam int unsigned RAMP_W     = 64;
  localparam int unsigned COLOR_W    = 4;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Fraction of the scaled row and its saturated value.
  localparam int unsigned FRAC_BITS = 6;
  localparam logic [FRAC_BITS-1:0] FRAC_MAX = 6'd63;

  // Largest surface extent honoured by the clipping logic.
  localparam logic [COORD_W-1:0] SURF_MAX = 12'd2048;

  // Default parameter values for the top level.
  localparam int unsigned RAMP_DEPTH_DEF = 16;
  localparam int unsigned COLOR_BITS_DEF = 4;

  // Configuration register indices.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ORIGIN_X       = 3'd0,
    CFG_ORIGIN_Y       = 3'd1,
    CFG_RECT_WIDTH     = 3'd2,
    CFG_RECT_HEIGHT    = 3'd3,
    CFG_RAMP_STEPS     = 3'd4,
    CFG_RAMP_COLORS    = 3'd5,
    CFG_SURFACE_WIDTH  = 3'd6,
    CFG_SURFACE_HEIGHT = 3'd7
  } cfg_idx_e;

  // Sideband that travels alongside the row division.
  typedef struct packed {
    logic             draw;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
  } side_t;

  // Standard 8x8 ordered dither thresholds, indexed by {y[2:0], x[2:0]}.
  localparam logic [5:0] BAYER_TAB [64] = '{
    6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

  // Threshold lookup for a pixel position.
  function automatic logic [5:0] bayer_thr(input logic [2:0] y, input logic [2:0] x);
    return BAYER_TAB[{y, x}];
  endfunction

endpackage

### hdl/dgf_divider.sv
// Pipelined restoring divider, one quotient bit per register stage, with a
// sideband that travels alongside. Depends on dgf_pkg for the sideband type.
module dgf_divider #(
  parameter int unsigned NUM_W = 21,
  parameter int unsigned QUO_W = 10,
  parameter int unsigned DEN_W = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  dgf_pkg::side_t    in_side_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              out_valid_o,
  output dgf_pkg::side_t    out_side_o,
  output logic [QUO_W-1:0]  quo_o
);

  // Remainder width holds the numerator and the largest shifted divisor.
  localparam int unsigned REM_W = (NUM_W > DEN_W + QUO_W - 1) ? NUM_W : DEN_W + QUO_W - 1;

  logic [QUO_W-1:0] vld_q;
  dgf_pkg::side_t   side_q [QUO_W];
  logic [QUO_W-1:0] quo_q  [QUO_W];
  logic [REM_W-1:0] rem_q  [QUO_W-1];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic             vld_in;
    dgf_pkg::side_t   side_in;
    logic [REM_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [REM_W-1:0] den_sh;
    logic             fits;
    logic [REM_W-1:0] rem_d;
    logic [QUO_W-1:0] quo_d;

    // Stage inputs come from the ports for the first stage, else the stage before.
    if (k == 0) begin : g_first
      assign vld_in  = in_valid_i;
      assign side_in = in_side_i;
      assign rem_in  = REM_W'(num_i);
      assign quo_in  = '0;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign side_in = side_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
    end

    // Trial subtraction of the divisor aligned to this quotient bit.
    always_comb begin
      den_sh = REM_W'(den_i) << (QUO_W - 1 - k);
      fits   = (rem_in >= den_sh);
      rem_d  = fits ? (rem_in - den_sh) : rem_in;
      quo_d  = quo_in;
      quo_d[QUO_W-1-k] = fits;
    end

    // Valid bit of the stage.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    // Payload of the stage.
    always_ff @(posedge clk_i) begin
      side_q[k] <= side_in;
      quo_q[k]  <= quo_d;
    end

    // The last stage needs no remainder.
    if (k < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[k] <= rem_d;
      end
    end
  end

  assign out_valid_o = vld_q[QUO_W-1];
  assign out_side_o  = side_q[QUO_W-1];
  assign quo_o       = quo_q[QUO_W-1];

endmodule

### hdl/dithered_gradient_fill_core.sv
// Dithered vertical gradient fill: one pixel transaction in, one result out.
// The path from start to done runs through one input stage, one stage per quotient
// bit of the row division and one output register.
// Throughput is one transaction per cycle; busy_o stays low and the receiver
// cannot stall. Reset clears the pipeline valid bits and loads the register
// reset values; it takes effect at once and needs no clearing pass.
module dithered_gradient_fill_core #(
  parameter int unsigned RAMP_DEPTH = dgf_pkg::RAMP_DEPTH_DEF,
  parameter int unsigned COLOR_BITS = dgf_pkg::COLOR_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [dgf_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [dgf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // Pixel command.
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [dgf_pkg::ROW_W-1:0]        row_i,
  input  logic [dgf_pkg::COL_W-1:0]        col_i,
  // Result.
  output logic                             done_o,
  output logic                             write_enable_o,
  output logic [dgf_pkg::PIX_W-1:0]        pixel_x_o,
  output logic [dgf_pkg::PIX_W-1:0]        pixel_y_o,
  output logic [dgf_pkg::COLOR_W-1:0]      color_o
);

  localparam int unsigned STEP_W = $clog2(RAMP_DEPTH);
  localparam int unsigned NUM_W  = dgf_pkg::ROW_W + STEP_W + dgf_pkg::FRAC_BITS;
  localparam int unsigned QUO_W  = STEP_W + dgf_pkg::FRAC_BITS;
  localparam int unsigned CW     = dgf_pkg::COORD_W;

  // Configuration registers.
  logic [CW-1:0]                  origin_x_q, origin_y_q;
  logic [CW-1:0]                  rect_width_q, rect_height_q;
  logic [dgf_pkg::STEPS_W-1:0]    ramp_steps_q;
  logic [dgf_pkg::RAMP_W-1:0]     ramp_colors_q;
  logic [CW-1:0]                  surface_width_q, surface_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q       <= '0;
      origin_y_q       <= '0;
      rect_width_q     <= '0;
      rect_height_q    <= '0;
      ramp_steps_q     <= 5'd2;
      ramp_colors_q    <= '0;
      surface_width_q  <= 12'd640;
      surface_height_q <= 12'd400;
    end else if (cfg_we_i) begin
      case (dgf_pkg::cfg_idx_e'(cfg_addr_i))
        dgf_pkg::CFG_ORIGIN_X:       origin_x_q       <= cfg_wdata_i[CW-1:0];
        dgf_pkg::CFG_ORIGIN_Y:       origin_y_q       <= cfg_wdata_i[CW-1:0];
        dgf_pkg::CFG_RECT_WIDTH:     rect_width_q     <= cfg_wdata_i[CW-1:0];
        dgf_pkg::CFG_RECT_HEIGHT:    rect_height_q    <= cfg_wdata_i[CW-1:0];
        dgf_pkg::CFG_RAMP_STEPS:     ramp_steps_q     <= cfg_wdata_i[dgf_pkg::STEPS_W-1:0];
        dgf_pkg::CFG_RAMP_COLORS:    ramp_colors_q    <= cfg_wdata_i[dgf_pkg::RAMP_W-1:0];
        dgf_pkg::CFG_SURFACE_WIDTH:  surface_width_q  <= cfg_wdata_i[CW-1:0];
        dgf_pkg::CFG_SURFACE_HEIGHT: surface_height_q <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Derived configuration: effective step count and clip extents.
  logic [dgf_pkg::STEPS_W-1:0] steps_eff;
  logic [STEP_W-1:0]           steps_m1;
  logic [CW-1:0]               sw_eff, sh_eff;

  always_comb begin
    steps_eff = (ramp_steps_q > dgf_pkg::STEPS_W'(RAMP_DEPTH)) ?
                dgf_pkg::STEPS_W'(RAMP_DEPTH) : ramp_steps_q;
    steps_m1  = STEP_W'(steps_eff - 5'd1);
    sw_eff    = (surface_width_q  > dgf_pkg::SURF_MAX) ? dgf_pkg::SURF_MAX : surface_width_q;
    sh_eff    = (surface_height_q > dgf_pkg::SURF_MAX) ? dgf_pkg::SURF_MAX : surface_height_q;
  end

  // The pipeline takes a transaction every cycle.
  assign busy_o = 1'b0;

  // Stage 0: surface position, clipping and the scaled numerator.
  logic signed [CW:0]                     dx, dy;
  logic                                   draw_d;
  logic [dgf_pkg::ROW_W+STEP_W-1:0]       prod;
  logic                                   s0_vld_q;
  dgf_pkg::side_t                         s0_side_q;
  logic [NUM_W-1:0]                       s0_num_q;

  always_comb begin
    dx = $signed({origin_x_q[CW-1], origin_x_q}) + $signed({2'b00, col_i});
    dy = $signed({origin_y_q[CW-1], origin_y_q}) + $signed({2'b00, row_i});
    draw_d = (steps_eff >= 5'd2) && (rect_height_q != '0) &&
             ({1'b0, row_i} < rect_height_q) && ({1'b0, col_i} < rect_width_q) &&
             !dx[CW] && (dx[CW-1:0] < sw_eff) &&
             !dy[CW] && (dy[CW-1:0] < sh_eff);
    prod = row_i * steps_m1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_side_q.draw <= draw_d;
    s0_side_q.px   <= dx[dgf_pkg::PIX_W-1:0];
    s0_side_q.py   <= dy[dgf_pkg::PIX_W-1:0];
    s0_num_q       <= {prod, dgf_pkg::FRAC_BITS'(0)};
  end

  // Row division by the rectangle height, one quotient bit per stage.
  logic              dv_vld;
  dgf_pkg::side_t    dv_side;
  logic [QUO_W-1:0]  dv_quo;

  dgf_divider #(
    .NUM_W (NUM_W),
    .QUO_W (QUO_W),
    .DEN_W (CW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s0_vld_q),
    .in_side_i   (s0_side_q),
    .num_i       (s0_num_q),
    .den_i       (rect_height_q),
    .out_valid_o (dv_vld),
    .out_side_o  (dv_side),
    .quo_o       (dv_quo)
  );

  // Ramp entries; bits above the top of the colour word read as zero.
  logic [COLOR_BITS-1:0] ramp_ent [RAMP_DEPTH];

  for (genvar k = 0; k < RAMP_DEPTH; k++) begin : g_ent
    for (genvar b = 0; b < COLOR_BITS; b++) begin : g_bit
      if (k * COLOR_BITS + b < dgf_pkg::RAMP_W) begin : g_in
        assign ramp_ent[k][b] = ramp_colors_q[k*COLOR_BITS+b];
      end else begin : g_out
        assign ramp_ent[k][b] = 1'b0;
      end
    end
  end

  // Final stage: band and fraction, clamp, dither compare and colour pick.
  logic [STEP_W-1:0]          band;
  logic [dgf_pkg::FRAC_BITS-1:0] frac;
  logic [5:0]                 thr;
  logic [STEP_W:0]            idx;
  logic [COLOR_BITS-1:0]      ent;
  logic                       done_q, we_q;
  logic [dgf_pkg::PIX_W-1:0]  px_q, py_q;
  logic [dgf_pkg::COLOR_W-1:0] color_q;

  always_comb begin
    band = dv_quo[QUO_W-1:dgf_pkg::FRAC_BITS];
    frac = dv_quo[dgf_pkg::FRAC_BITS-1:0];
    if (band >= steps_m1) begin
      band = steps_m1 - 1'b1;
      frac = dgf_pkg::FRAC_MAX;
    end
    thr = dgf_pkg::bayer_thr(dv_side.py[2:0], dv_side.px[2:0]);
    idx = (thr < frac) ? ({1'b0, band} + 1'b1) : {1'b0, band};
    ent = '0;
    for (int k = 0; k < RAMP_DEPTH; k++) begin
      if (idx == (STEP_W + 1)'(k)) begin
        ent = ramp_ent[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld;
    end
  end

  // A clipped or disabled pixel reports zero coordinates and colour.
  always_ff @(posedge clk_i) begin
    we_q    <= dv_side.draw;
    px_q    <= dv_side.draw ? dv_side.px : '0;
    py_q    <= dv_side.draw ? dv_side.py : '0;
    color_q <= dv_side.draw ? dgf_pkg::COLOR_W'(ent) : '0;
  end

  assign done_o         = done_q;
  assign write_enable_o = we_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign color_o        = color_q;

endmodule

### test/dithered_gradient_fill_core_tb.sv
// Self-checking testbench for dithered_gradient_fill_core: directed and random pixel
// transactions over many register settings, each result checked against a local predictor.
// Depends on dgf_pkg and the dithered_gradient_fill_core RTL only.
module dithered_gradient_fill_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Pipeline depth from start to done, and the watchdog limit on cycles without progress.
  localparam int PIPE_LAT    = $clog2(dgf_pkg::RAMP_DEPTH_DEF) + 8;
  localparam int STALL_LIMIT = 1000;

  // One result transaction as seen on the output ports.
  typedef struct packed {
    logic                        we;
    logic [dgf_pkg::PIX_W-1:0]   x;
    logic [dgf_pkg::PIX_W-1:0]   y;
    logic [dgf_pkg::COLOR_W-1:0] color;
  } fill_px_t;

  // A complete register setting for one phase of the run.
  typedef struct {
    logic [dgf_pkg::COORD_W-1:0] ox, oy, rw, rh, sw, sh;
    logic [dgf_pkg::STEPS_W-1:0] steps;
    logic [dgf_pkg::RAMP_W-1:0]  colors;
  } fill_cfg_t;

  // Mirror of the registers, gradient predictor and queue of pixels still to come out.
  class fill_scoreboard;
    logic [dgf_pkg::COORD_W-1:0] org_x, org_y, rect_w, rect_h, surf_w, surf_h;
    logic [dgf_pkg::STEPS_W-1:0] steps;
    logic [dgf_pkg::RAMP_W-1:0]  ramp;
    fill_px_t                    pending_q[$];
    int unsigned                 fail_cnt;

    function new();
      org_x    = '0;
      org_y    = '0;
      rect_w   = '0;
      rect_h   = '0;
      steps    = 5'd2;
      ramp     = '0;
      surf_w   = 12'd640;
      surf_h   = 12'd400;
      fail_cnt = 0;
    endfunction

    function void write_reg(dgf_pkg::cfg_idx_e idx, logic [dgf_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        dgf_pkg::CFG_ORIGIN_X:       org_x  = v[dgf_pkg::COORD_W-1:0];
        dgf_pkg::CFG_ORIGIN_Y:       org_y  = v[dgf_pkg::COORD_W-1:0];
        dgf_pkg::CFG_RECT_WIDTH:     rect_w = v[dgf_pkg::COORD_W-1:0];
        dgf_pkg::CFG_RECT_HEIGHT:    rect_h = v[dgf_pkg::COORD_W-1:0];
        dgf_pkg::CFG_RAMP_STEPS:     steps  = v[dgf_pkg::STEPS_W-1:0];
        dgf_pkg::CFG_RAMP_COLORS:    ramp   = v[dgf_pkg::RAMP_W-1:0];
        dgf_pkg::CFG_SURFACE_WIDTH:  surf_w = v[dgf_pkg::COORD_W-1:0];
        dgf_pkg::CFG_SURFACE_HEIGHT: surf_h = v[dgf_pkg::COORD_W-1:0];
        default: ;
      endcase
    endfunction

    // Ordered dither threshold built by bit interleaving rather than by lookup.
    function logic [5:0] dither_thr(logic [2:0] y, logic [2:0] x);
      logic [2:0] d;
      d = x ^ y;
      return {d[0], y[0], d[1], y[1], d[2], y[2]};
    endfunction

    function fill_px_t predict_pixel(logic [dgf_pkg::ROW_W-1:0] row,
                                     logic [dgf_pkg::COL_W-1:0] col);
      fill_px_t   px;
      int         n, lim_w, lim_h, dx, dy, t, band, frac, k;
      logic [5:0] thr;
      px    = '0;
      n     = (steps > dgf_pkg::RAMP_DEPTH_DEF) ? dgf_pkg::RAMP_DEPTH_DEF : int'(steps);
      lim_w = (surf_w > dgf_pkg::SURF_MAX) ? int'(dgf_pkg::SURF_MAX) : int'(surf_w);
      lim_h = (surf_h > dgf_pkg::SURF_MAX) ? int'(dgf_pkg::SURF_MAX) : int'(surf_h);
      dx    = int'($signed(org_x)) + int'(col);
      dy    = int'($signed(org_y)) + int'(row);
      // Disabled ramp, empty rectangle, outside the rectangle or off the surface.
      if (n < 2 || rect_h == 0 || row >= rect_h || col >= rect_w ||
          dx < 0 || dx >= lim_w || dy < 0 || dy >= lim_h)
        return px;
      t    = (int'(row) * (n - 1) * 64) / int'(rect_h);
      band = t >> dgf_pkg::FRAC_BITS;
      frac = t & 63;
      // The band saturates at the last step with a full fraction.
      if (band >= n - 1) begin
        band = n - 2;
        frac = 63;
      end
      thr      = dither_thr(dy[2:0], dx[2:0]);
      k        = (int'(thr) < frac) ? band + 1 : band;
      px.we    = 1'b1;
      px.x     = dx[dgf_pkg::PIX_W-1:0];
      px.y     = dy[dgf_pkg::PIX_W-1:0];
      px.color = (k * dgf_pkg::COLOR_W >= dgf_pkg::RAMP_W) ? '0 :
                 ramp[k*dgf_pkg::COLOR_W +: dgf_pkg::COLOR_W];
      return px;
    endfunction

    function void note_pixel(logic [dgf_pkg::ROW_W-1:0] row, logic [dgf_pkg::COL_W-1:0] col);
      pending_q.push_back(predict_pixel(row, col));
    endfunction

    function void check_pixel(fill_px_t got);
      fill_px_t want;
      if (pending_q.size() == 0) begin
        $error("result with no transaction outstanding: we=%0d x=%0d y=%0d color=%0d",
               got.we, got.x, got.y, got.color);
        fail_cnt++;
        return;
      end
      want = pending_q.pop_front();
      if (got.we !== want.we) begin
        $error("write_enable mismatch: expected %0d, actual %0d", want.we, got.we);
        fail_cnt++;
      end
      if (got.x !== want.x) begin
        $error("pixel_x mismatch: expected %0d, actual %0d", want.x, got.x);
        fail_cnt++;
      end
      if (got.y !== want.y) begin
        $error("pixel_y mismatch: expected %0d, actual %0d", want.y, got.y);
        fail_cnt++;
      end
      if (got.color !== want.color) begin
        $error("color mismatch: expected %0d, actual %0d", want.color, got.color);
        fail_cnt++;
      end
    endfunction

    function bit drained();
      return pending_q.size() == 0;
    endfunction
  endclass

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              cfg_we_i    = 1'b0;
  logic [dgf_pkg::CFG_ADDR_W-1:0]    cfg_addr_i  = '0;
  logic [dgf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i = '0;
  logic                              start_i     = 1'b0;
  logic [dgf_pkg::ROW_W-1:0]         row_i       = '0;
  logic [dgf_pkg::COL_W-1:0]         col_i       = '0;
  logic                              busy_o;
  logic                              done_o;
  logic                              write_enable_o;
  logic [dgf_pkg::PIX_W-1:0]         pixel_x_o;
  logic [dgf_pkg::PIX_W-1:0]         pixel_y_o;
  logic [dgf_pkg::COLOR_W-1:0]       color_o;

  fill_scoreboard sb = new();
  int             stall_cnt = 0;

  dithered_gradient_fill_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .row_i          (row_i),
    .col_i          (col_i),
    .done_o         (done_o),
    .write_enable_o (write_enable_o),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .color_o        (color_o)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Monitor: mirror register writes, record accepted pixels, check results, watch for hangs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(dgf_pkg::cfg_idx_e'(cfg_addr_i), cfg_wdata_i);
      if (start_i && !busy_o) sb.note_pixel(row_i, col_i);
      if (done_o) sb.check_pixel('{write_enable_o, pixel_x_o, pixel_y_o, color_o});
      if (cfg_we_i || (start_i && !busy_o) || done_o) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("** dithered_gradient_fill_core: FAILED **");
        $finish;
      end
    end
  end

  // Present one pixel transaction and hold it until the block takes it.
  task automatic send_pixel(input logic [dgf_pkg::ROW_W-1:0] r,
                            input logic [dgf_pkg::COL_W-1:0] c);
    start_i <= 1'b1;
    row_i   <= r;
    col_i   <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Idle gap on the command side, with junk on the payload.
  task automatic pause(input int n);
    start_i <= 1'b0;
    row_i   <= dgf_pkg::ROW_W'($urandom);
    col_i   <= dgf_pkg::COL_W'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic write_reg(input dgf_pkg::cfg_idx_e idx,
                           input logic [dgf_pkg::CFG_DATA_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write every register; bits above each register's width carry junk that must be ignored.
  task automatic apply_cfg(input fill_cfg_t c);
    logic [dgf_pkg::CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(dgf_pkg::CFG_ORIGIN_X,       {junk[63:12], c.ox});
    write_reg(dgf_pkg::CFG_ORIGIN_Y,       {junk[63:12], c.oy});
    write_reg(dgf_pkg::CFG_RECT_WIDTH,     {junk[63:12], c.rw});
    write_reg(dgf_pkg::CFG_RECT_HEIGHT,    {junk[63:12], c.rh});
    write_reg(dgf_pkg::CFG_RAMP_STEPS,     {junk[63:5], c.steps});
    write_reg(dgf_pkg::CFG_RAMP_COLORS,    c.colors);
    write_reg(dgf_pkg::CFG_SURFACE_WIDTH,  {junk[63:12], c.sw});
    write_reg(dgf_pkg::CFG_SURFACE_HEIGHT, {junk[63:12], c.sh});
    end_writes();
  endtask

  // Wait for every outstanding pixel, then let the pipeline empty.
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (!sb.drained()) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  function automatic fill_cfg_t mk_cfg(input int ox, oy, rw, rh, steps,
                                       input logic [dgf_pkg::RAMP_W-1:0] colors,
                                       input int sw, sh);
    fill_cfg_t c;
    c.ox     = dgf_pkg::COORD_W'(ox);
    c.oy     = dgf_pkg::COORD_W'(oy);
    c.rw     = dgf_pkg::COORD_W'(rw);
    c.rh     = dgf_pkg::COORD_W'(rh);
    c.steps  = dgf_pkg::STEPS_W'(steps);
    c.colors = colors;
    c.sw     = dgf_pkg::COORD_W'(sw);
    c.sh     = dgf_pkg::COORD_W'(sh);
    return c;
  endfunction

  // Mostly usable settings, with a share of odd ones: disabled ramps, oversized values.
  function automatic fill_cfg_t rand_cfg();
    fill_cfg_t c;
    int        sel;
    c.ox = ($urandom_range(0, 4) == 0) ? dgf_pkg::COORD_W'($urandom)
                                       : dgf_pkg::COORD_W'(int'($urandom_range(0, 320)) - 64);
    c.oy = ($urandom_range(0, 4) == 0) ? dgf_pkg::COORD_W'($urandom)
                                       : dgf_pkg::COORD_W'(int'($urandom_range(0, 320)) - 64);
    c.rw = ($urandom_range(0, 4) == 0) ? dgf_pkg::COORD_W'($urandom)
                                       : dgf_pkg::COORD_W'($urandom_range(1, 300));
    c.rh = ($urandom_range(0, 4) == 0) ? dgf_pkg::COORD_W'($urandom)
                                       : dgf_pkg::COORD_W'($urandom_range(1, 300));
    sel = $urandom_range(0, 9);
    if (sel == 0) c.steps = dgf_pkg::STEPS_W'($urandom_range(0, 1));
    else if (sel == 1) c.steps = dgf_pkg::STEPS_W'($urandom_range(17, 31));
    else c.steps = dgf_pkg::STEPS_W'($urandom_range(2, 16));
    c.colors = {$urandom, $urandom};
    c.sw = ($urandom_range(0, 4) == 0) ? dgf_pkg::COORD_W'($urandom)
                                       : dgf_pkg::COORD_W'($urandom_range(64, 2048));
    c.sh = ($urandom_range(0, 4) == 0) ? dgf_pkg::COORD_W'($urandom)
                                       : dgf_pkg::COORD_W'($urandom_range(64, 2048));
    return c;
  endfunction

  // Stimulus sequence.
  initial begin
    fill_cfg_t                 c;
    int                        idle_lvl, lim_h, lim_w;
    logic [dgf_pkg::ROW_W-1:0] row_v;
    logic [dgf_pkg::COL_W-1:0] col_v;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Straight after reset the rectangle is empty, so nothing is drawn.
    send_pixel(0, 0);
    send_pixel(2047, 2047);
    settle();

    // Give the rectangle a size and the ramp its colours; steps, surface and origin keep their reset values.
    write_reg(dgf_pkg::CFG_RECT_WIDTH, 64);
    write_reg(dgf_pkg::CFG_RECT_HEIGHT, 64);
    write_reg(dgf_pkg::CFG_RAMP_COLORS, 64'h0000_0000_0000_00A5);
    end_writes();
    send_pixel(0, 0);
    send_pixel(63, 63);
    send_pixel(32, 10);
    send_pixel(64, 0);
    settle();

    // Full-size rectangle and surface with a sixteen-colour ramp.
    apply_cfg(mk_cfg(0, 0, 2048, 2048, 16, 64'hFEDC_BA98_7654_3210, 2048, 2048));
    send_pixel(0, 0);
    send_pixel(2047, 2047);
    send_pixel(0, 2047);
    send_pixel(2047, 0);
    send_pixel(1024, 1023);
    send_pixel(127, 3);
    send_pixel(1, 6);
    settle();

    // Oversized steps and surface values, and an origin partly off the surface.
    apply_cfg(mk_cfg(100, -20, 4095, 4095, 31, 64'h0123_4567_89AB_CDEF, 4095, 4095));
    send_pixel(19, 0);
    send_pixel(20, 0);
    send_pixel(2047, 1947);
    send_pixel(100, 1948);
    send_pixel(2047, 2047);
    settle();

    // Origin at its positive extreme: only the first pixel lands on the surface.
    apply_cfg(mk_cfg(2047, 2047, 16, 16, 2, 64'h0000_0000_0000_003C, 2048, 2048));
    send_pixel(0, 0);
    send_pixel(0, 1);
    settle();

    // Origin at its negative extreme.
    apply_cfg(mk_cfg(-2048, -2048, 4095, 4095, 16, '1, 2048, 2048));
    send_pixel(2047, 2047);
    settle();

    // Disabled ramp with one or no steps, and a zero-height rectangle.
    apply_cfg(mk_cfg(0, 0, 100, 100, 1, '1, 640, 400));
    send_pixel(5, 5);
    settle();
    apply_cfg(mk_cfg(0, 0, 100, 100, 0, '1, 640, 400));
    send_pixel(5, 5);
    settle();
    apply_cfg(mk_cfg(0, 0, 100, 0, 16, '1, 640, 400));
    send_pixel(0, 5);
    settle();

    // Random phases; the last one runs without idling.
    for (int p = 0; p < 8; p++) begin
      c = rand_cfg();
      apply_cfg(c);
      idle_lvl = (p == 7) ? 0 : $urandom_range(0, 2);
      lim_h = (c.rh > 2048) ? 2048 : int'(c.rh);
      lim_w = (c.rw > 2048) ? 2048 : int'(c.rw);
      repeat (60) begin
        // Mostly pixels inside the rectangle, the rest anywhere.
        if ($urandom_range(0, 4) != 0 && lim_h != 0 && lim_w != 0) begin
          row_v = dgf_pkg::ROW_W'($urandom_range(0, lim_h - 1));
          col_v = dgf_pkg::COL_W'($urandom_range(0, lim_w - 1));
        end else begin
          row_v = dgf_pkg::ROW_W'($urandom);
          col_v = dgf_pkg::COL_W'($urandom);
        end
        send_pixel(row_v, col_v);
        if (idle_lvl != 0 && $urandom_range(0, 9) < idle_lvl * 2)
          pause($urandom_range(1, 10));
      end
      settle();
    end

    if (sb.fail_cnt == 0)
      $display("** dithered_gradient_fill_core: PASSED **");
    else
      $display("** dithered_gradient_fill_core: FAILED **");
    $finish;
  end

endmodule
